### rtl/stcl_pkg.sv
// ============================================================================
// stcl_pkg
// Shared constants and types for the sample time calibration lookup.
// ============================================================================
`default_nettype none

package stcl_pkg;

    // time axis table geometry
    localparam int AXIS_SIZE   = 256;
    localparam int AXIS_W      = 8;     // log2(AXIS_SIZE), also search step count
    localparam int WINDOW_SH   = 6;     // log2(WINDOW_SIZE), WINDOW_SIZE = 64
    localparam int ENTRY_W     = 16;
    localparam int STEP_W      = 3;     // counts AXIS_W search steps

    // serial divider
    localparam int DIV_W       = 34;    // dividend / quotient width
    localparam int DVS_W       = 18;    // divisor / remainder width
    localparam int DIV_CNT_W   = 6;

    localparam logic [15:0] TIME_RANGE_RST = 16'd48238;

    // operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_S2T    = 2'd1;
    localparam logic [1:0] OP_T2S    = 2'd2;
    localparam logic [1:0] OP_BINW   = 2'd3;

    // configuration register indexes
    localparam logic REG_TIME_RANGE = 1'b0;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
        logic [DVS_W-1:0]   remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

### rtl/stcl_ram.sv
// ============================================================================
// stcl_ram
// Generic single-port synchronous RAM with registered read data.
// ============================================================================
`default_nettype none

module stcl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/stcl_div.sv
// ============================================================================
// stcl_div
// Unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module stcl_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stcl_pkg::div_req_t req,
    output stcl_pkg::div_rsp_t     rsp
);

    logic [stcl_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [stcl_pkg::DVS_W-1:0]     rem_reg, rem_next;
    logic [stcl_pkg::DVS_W-1:0]     dvs_reg, dvs_next;
    logic [stcl_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           run_reg, run_next;
    logic                           done_reg, done_next;
    logic [stcl_pkg::DVS_W:0]       trial;
    logic [stcl_pkg::DVS_W:0]       diff;
    logic                           ge;

    assign trial = {rem_reg, quo_reg[stcl_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
            cnt_next = stcl_pkg::DIV_CNT_W'(stcl_pkg::DIV_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[stcl_pkg::DVS_W-1:0] : trial[stcl_pkg::DVS_W-1:0];
            quo_next = {quo_reg[stcl_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == stcl_pkg::DIV_CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

### rtl/sample_time_calibration_lookup.sv
// ============================================================================
// sample_time_calibration_lookup
// Calibrated time-axis table with sample/time conversion and bin width query.
// ============================================================================
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------
//  command   | start / busy          | operation, window, sample_in, ...
//  result    | done (1-cycle strobe) | time_out, sample_out, bin_width, ...
//  config    | APB psel/penable      | time_range at paddr 0
//
//  Write entry: table written when the command is accepted. Sample-to-time
//  and bin width: two table reads on the single RAM port. Time-to-sample:
//  two passes of the 34-step serial divider around an 8-step binary search
//  over the table; no second divide when the search lands on a zero-width bin.
//  Reset returns control to idle and time_range to its default; table
//  contents are undefined until written. Results cannot be stalled; a new
//  transaction may start in the cycle its predecessor's result is shown.
//
`default_nettype none

module sample_time_calibration_lookup (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [8:0]  window,
    input  wire logic signed [16:0] sample_in,
    input  wire logic signed [8:0]  sample_number,
    input  wire logic signed [31:0] time_in,
    input  wire logic [7:0]  entry_index,
    input  wire logic [15:0] entry_value,
    // result
    output logic             done,
    output logic signed [31:0] time_out,
    output logic signed [31:0] sample_out,
    output logic [15:0]      bin_width,
    output logic             zero_bin_error,
    // config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_LA   = 10'b0000000010,
        ST_LB   = 10'b0000000100,
        ST_U    = 10'b0000001000,
        ST_DIV1 = 10'b0000010000,
        ST_SRCH = 10'b0000100000,
        ST_R1   = 10'b0001000000,
        ST_R2   = 10'b0010000000,
        ST_DIV2 = 10'b0100000000,
        ST_SUM  = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;

    logic [15:0]        time_range_reg, time_range_next;
    logic [1:0]         op_reg, op_next;
    logic [8:0]         win_reg, win_next;
    logic [7:0]         k_reg, k_next;
    logic [7:0]         f_reg, f_next;
    logic signed [8:0]  n1_reg, n1_next;
    logic [15:0]        a_reg, a_next;
    logic signed [25:0] np_reg, np_next;
    logic signed [34:0] u_reg, u_next;
    logic signed [34:0] nq_reg, nq_next;
    logic [17:0]        t_reg, t_next;
    logic [7:0]         i1_reg, i1_next;
    logic [8:0]         i2_reg, i2_next;
    logic [stcl_pkg::STEP_W-1:0] step_reg, step_next;
    logic               neg_reg, neg_next;
    logic signed [26:0] fr_reg, fr_next;
    logic               zb_reg, zb_next;

    logic               done_reg, done_next;
    logic [31:0]        time_out_reg, time_out_next;
    logic [31:0]        sample_out_reg, sample_out_next;
    logic [15:0]        bin_width_reg, bin_width_next;
    logic               zero_bin_reg, zero_bin_next;

    logic               ram_we;
    logic [7:0]         ram_addr;
    logic [15:0]        ram_rdata;

    stcl_pkg::div_req_t div_req;
    stcl_pkg::div_rsp_t div_rsp;

    logic               accept;
    logic               cfg_wr;
    logic [15:0]        per_val;
    logic [17:0]        per4;
    logic signed [16:0] sn;
    logic [24:0]        win_p;
    logic [15:0]        b_val;
    logic signed [16:0] diff;
    logic signed [25:0] prod;
    logic [31:0]        s2t_sum;
    logic [34:0]        u_abs;
    logic               rz;
    logic [34:0]        q_inc;
    logic               go_right;
    logic [7:0]         i1_new;
    logic [8:0]         i2_new;
    logic [8:0]         mid_cur;
    logic [8:0]         mid_new;
    logic signed [18:0] dlt;
    logic signed [18:0] dd4;
    logic signed [26:0] num;
    logic [26:0]        num_abs;
    logic [18:0]        d_abs;
    logic [26:0]        q2_inc;
    logic signed [53:0] t2s_sum;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == stcl_pkg::REG_TIME_RANGE) ? {16'b0, time_range_reg}
                                                             : 32'b0;

    assign per_val = (time_range_reg == 16'd0) ? 16'd1 : time_range_reg;
    assign per4    = {per_val, 2'b00};

    // accept-cycle arithmetic
    assign sn    = 17'($signed({{8{sample_in[16]}}, sample_in[16:8]}))
                 + $signed({2'b00, window, 6'b0});
    assign win_p = {16'b0, window} * {9'b0, per_val};

    // table bin end, closing entry is the period
    assign b_val = ((state_reg == ST_LB) ? (k_reg == 8'hFF) : i2_reg[8]) ? per_val
                                                                      : ram_rdata;
    assign diff  = $signed({1'b0, b_val}) - $signed({1'b0, a_reg});
    assign prod  = $signed({{9{diff[16]}}, diff}) * $signed({18'b0, f_reg});
    assign s2t_sum = 32'($signed({{6{np_reg[25]}}, np_reg}))
                   + {16'b0, a_reg}
                   + 32'($signed({{14{prod[25]}}, prod[25:8]}));

    assign u_abs = u_reg[34] ? (35'd0 - u_reg) : u_reg;
    assign rz    = (div_rsp.remainder == '0);
    assign q_inc = {1'b0, div_rsp.quotient} + {34'b0, !rz};

    // binary search step
    assign mid_cur  = (9'({1'b0, i1_reg}) + i2_reg) >> 1;
    assign go_right = (t_reg > {ram_rdata, 2'b00});
    assign i1_new   = go_right ? mid_cur[7:0] : i1_reg;
    assign i2_new   = go_right ? i2_reg : mid_cur;
    assign mid_new  = (9'({1'b0, i1_new}) + i2_new) >> 1;

    assign dlt     = $signed({1'b0, t_reg}) - $signed({1'b0, a_reg, 2'b00});
    assign num     = $signed({dlt, 8'b0});
    assign dd4     = $signed({diff, 2'b00});
    assign num_abs = num[26] ? (27'd0 - num) : num;
    assign d_abs   = dd4[18] ? (19'd0 - dd4) : dd4;
    assign q2_inc  = div_rsp.quotient[26:0] + {26'b0, !rz};

    assign t2s_sum = $signed({{3{nq_reg[34]}}, nq_reg, 16'b0})
                   - $signed({31'b0, win_reg, 14'b0})
                   + $signed({38'b0, i1_reg, 8'b0})
                   + $signed({{27{fr_reg[26]}}, fr_reg});

    always_comb
    begin
        state_next      = state_reg;
        time_range_next = time_range_reg;
        op_next         = op_reg;
        win_next        = win_reg;
        k_next          = k_reg;
        f_next          = f_reg;
        n1_next         = n1_reg;
        a_next          = a_reg;
        np_next         = np_reg;
        u_next          = u_reg;
        nq_next         = nq_reg;
        t_next          = t_reg;
        i1_next         = i1_reg;
        i2_next         = i2_reg;
        step_next       = step_reg;
        neg_next        = neg_reg;
        fr_next         = fr_reg;
        zb_next         = zb_reg;
        done_next       = 1'b0;
        time_out_next   = time_out_reg;
        sample_out_next = sample_out_reg;
        bin_width_next  = bin_width_reg;
        zero_bin_next   = zero_bin_reg;
        ram_we          = 1'b0;
        ram_addr        = k_reg;
        div_req.start    = 1'b0;
        div_req.dividend = 34'(u_abs);
        div_req.divisor  = per4;

        if (cfg_wr && (paddr[2] == stcl_pkg::REG_TIME_RANGE))
        begin
            time_range_next = pwdata[15:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next  = operation;
                    win_next = window;
                    case (operation)
                        stcl_pkg::OP_WRITE:
                        begin
                            ram_we          = 1'b1;
                            ram_addr        = entry_index;
                            done_next       = 1'b1;
                            time_out_next   = '0;
                            sample_out_next = '0;
                            bin_width_next  = '0;
                            zero_bin_next   = 1'b0;
                        end
                        stcl_pkg::OP_S2T:
                        begin
                            k_next     = sn[7:0];
                            n1_next    = sn[16:8];
                            f_next     = sample_in[7:0];
                            ram_addr   = sn[7:0];
                            state_next = ST_LA;
                        end
                        stcl_pkg::OP_T2S:
                        begin
                            u_next     = $signed({time_in[31], time_in, 2'b00})
                                       + $signed({10'b0, win_p});
                            state_next = ST_U;
                        end
                        default:
                        begin
                            k_next     = {window[1:0], 6'b0} + sample_number[7:0];
                            ram_addr   = {window[1:0], 6'b0} + sample_number[7:0];
                            state_next = ST_LA;
                        end
                    endcase
                end
            end
            ST_LA:
            begin
                a_next     = ram_rdata;
                np_next    = $signed({{17{n1_reg[8]}}, n1_reg}) * $signed({10'b0, per_val});
                ram_addr   = k_reg + 8'd1;
                state_next = ST_LB;
            end
            ST_LB:
            begin
                done_next       = 1'b1;
                sample_out_next = '0;
                zero_bin_next   = 1'b0;
                if (op_reg == stcl_pkg::OP_S2T)
                begin
                    time_out_next  = s2t_sum;
                    bin_width_next = '0;
                end
                else
                begin
                    time_out_next  = '0;
                    bin_width_next = diff[16] ? 16'd0 : diff[15:0];
                end
                state_next = ST_IDLE;
            end
            ST_U:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (div_rsp.done)
                begin
                    if (u_reg[34])
                    begin
                        nq_next = 35'd0 - q_inc;
                        t_next  = rz ? 18'd0 : (per4 - div_rsp.remainder);
                    end
                    else
                    begin
                        nq_next = {1'b0, div_rsp.quotient};
                        t_next  = div_rsp.remainder;
                    end
                    i1_next    = '0;
                    i2_next    = 9'(stcl_pkg::AXIS_SIZE);
                    step_next  = '0;
                    ram_addr   = 8'(stcl_pkg::AXIS_SIZE / 2);
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                i1_next   = i1_new;
                i2_next   = i2_new;
                step_next = step_reg + 1'b1;
                if (step_reg == stcl_pkg::STEP_W'(stcl_pkg::AXIS_W - 1))
                begin
                    ram_addr   = i1_new;
                    state_next = ST_R1;
                end
                else
                begin
                    ram_addr = mid_new[7:0];
                end
            end
            ST_R1:
            begin
                a_next     = ram_rdata;
                ram_addr   = i2_reg[7:0];
                state_next = ST_R2;
            end
            ST_R2:
            begin
                if (diff == 17'sd0)
                begin
                    zb_next    = 1'b1;
                    fr_next    = '0;
                    state_next = ST_SUM;
                end
                else
                begin
                    zb_next          = 1'b0;
                    neg_next         = num[26] ^ dd4[18];
                    div_req.start    = 1'b1;
                    div_req.dividend = {7'b0, num_abs};
                    div_req.divisor  = d_abs[17:0];
                    state_next       = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_rsp.done)
                begin
                    fr_next    = neg_reg ? (27'd0 - q2_inc) : div_rsp.quotient[26:0];
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                done_next      = 1'b1;
                time_out_next  = '0;
                bin_width_next = '0;
                zero_bin_next  = zb_reg;
                if ((t2s_sum[53:31] != '0) && (t2s_sum[53:31] != '1))
                begin
                    sample_out_next = t2s_sum[53] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                else
                begin
                    sample_out_next = t2s_sum[31:0];
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            time_range_reg <= stcl_pkg::TIME_RANGE_RST;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            time_range_reg <= time_range_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        win_reg        <= win_next;
        k_reg          <= k_next;
        f_reg          <= f_next;
        n1_reg         <= n1_next;
        a_reg          <= a_next;
        np_reg         <= np_next;
        u_reg          <= u_next;
        nq_reg         <= nq_next;
        t_reg          <= t_next;
        i1_reg         <= i1_next;
        i2_reg         <= i2_next;
        step_reg       <= step_next;
        neg_reg        <= neg_next;
        fr_reg         <= fr_next;
        zb_reg         <= zb_next;
        time_out_reg   <= time_out_next;
        sample_out_reg <= sample_out_next;
        bin_width_reg  <= bin_width_next;
        zero_bin_reg   <= zero_bin_next;
    end

    stcl_ram #(
        .WIDTH (stcl_pkg::ENTRY_W),
        .DEPTH (stcl_pkg::AXIS_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (entry_value),
        .rdata (ram_rdata)
    );

    stcl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign done           = done_reg;
    assign time_out       = time_out_reg;
    assign sample_out     = sample_out_reg;
    assign bin_width      = bin_width_reg;
    assign zero_bin_error = zero_bin_reg;

`ifndef NO_ASSERTIONS
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $countones({time_out != 0, sample_out != 0, bin_width != 0}) <= 1)
        else $error("more than one result field set");

    a_zb_t2s: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_bin_error) |-> (time_out == 0 && bin_width == 0))
        else $error("zero bin flag outside time to sample");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> (state_reg == ST_DIV1 || state_reg == ST_DIV2))
        else $error("divider started outside a divide state");

    a_wr_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (accept && operation == stcl_pkg::OP_WRITE))
        else $error("table write outside a write transaction");

    a_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH) |-> (i2_reg > 9'({1'b0, i1_reg}) + 9'd1))
        else $error("search interval collapsed");
`endif

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sample time calibration lookup testbench
// Fills the time-axis table, runs directed and random table writes and
// conversion commands under several periods set through the APB port, and
// checks each result strobe against an in-bench prediction of the lookup.
// ----------------------------------------------------------------------------
module testbench;
    import stcl_pkg::*;

    localparam int  WIN_SIZE   = 64;
    localparam int  WDOG_LIMIT = 5000;
    localparam int  RAND_ITEMS = 60;

    typedef struct {
        logic [1:0]         op;
        logic [8:0]         win;
        logic signed [16:0] smp;
        logic signed [8:0]  snum;
        logic signed [31:0] tin;
        logic [7:0]         idx;
        logic [15:0]        val;
    } command_t;

    typedef struct {
        logic signed [31:0] t_out;
        logic signed [31:0] s_out;
        logic [15:0]        width;
        logic               zbin;
    } lookup_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] operation = '0;
    logic [8:0] window = '0;
    logic signed [16:0] sample_in = '0;
    logic signed [8:0] sample_number = '0;
    logic signed [31:0] time_in = '0;
    logic [7:0] entry_index = '0;
    logic [15:0] entry_value = '0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic busy, done, zero_bin_error, pready;
    logic signed [31:0] time_out, sample_out;
    logic [15:0] bin_width;
    logic [31:0] prdata;

    command_t pending_cmds[$];
    lookup_t  expected_lookups[$];
    logic [15:0] axis_tbl[AXIS_SIZE];
    logic [15:0] range_reg = TIME_RANGE_RST;
    int  errors = 0;
    int  idle_cycles = 0;
    int  gap = 0;
    bit  no_idle = 1'b0;
    bit  drain = 1'b0;
    command_t cur;

    always #5 clk = ~clk;

    sample_time_calibration_lookup DUT (.*);

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0)))
            q--;
        return q;
    endfunction

    function automatic longint period_val();
        return (range_reg == 16'd0) ? 64'sd1 : longint'(range_reg);
    endfunction

    function automatic longint axis_entry(longint i);
        if (i >= 0 && i < AXIS_SIZE)
            return longint'(axis_tbl[i]);
        return period_val();
    endfunction

    function automatic logic signed [31:0] clamp32(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    // applies one command to the table copy and returns the lookup result
    function automatic lookup_t predict_lookup(command_t c);
        lookup_t r;
        longint p, w, s, f, sn, n, k, tk, u, t, i1, i2, mid, d, fr, i;
        r = '{0, 0, 0, 1'b0};
        p = period_val();
        w = longint'(c.win);
        case (c.op)
            OP_WRITE: axis_tbl[c.idx] = c.val;
            OP_S2T:
            begin
                s  = longint'(c.smp);
                f  = s - floor_div(s, 256) * 256;
                sn = floor_div(s, 256) + w * WIN_SIZE;
                n  = floor_div(sn, AXIS_SIZE);
                k  = sn - n * AXIS_SIZE;
                tk = axis_entry(k);
                r.t_out = clamp32(n * p + tk + floor_div((axis_entry(k + 1) - tk) * f, 256));
            end
            OP_T2S:
            begin
                u  = 4 * longint'(c.tin) + w * p;
                n  = floor_div(u, 4 * p);
                t  = u - 4 * p * n;
                i1 = 0;
                i2 = AXIS_SIZE;
                fr = 0;
                while (i2 - i1 > 1)
                begin
                    mid = (i1 + i2) / 2;
                    if (t > 4 * axis_entry(mid))
                        i1 = mid;
                    else
                        i2 = mid;
                end
                d = 4 * (axis_entry(i2) - axis_entry(i1));
                if (d == 0)
                    r.zbin = 1'b1;
                else
                    fr = floor_div(256 * (t - 4 * axis_entry(i1)), d);
                r.s_out = clamp32((n * AXIS_SIZE - w * WIN_SIZE + i1) * 256 + fr);
            end
            default:
            begin
                i = floor_div(w * WIN_SIZE + longint'(c.snum), AXIS_SIZE);
                i = w * WIN_SIZE + longint'(c.snum) - i * AXIS_SIZE;
                d = axis_entry(i + 1) - axis_entry(i);
                r.width = (d < 0) ? 16'd0 : d[15:0];
            end
        endcase
        return r;
    endfunction

    function automatic command_t make_cmd(logic [1:0] op);
        command_t c;
        longint p;
        c.op   = op;
        c.win  = 9'($urandom_range(511));
        c.smp  = 17'(($urandom_range(3) == 0) ? $urandom
                                               : $signed($urandom_range(8191)) - 4096);
        c.snum = 9'($urandom);
        p = period_val();
        if ($urandom_range(4) == 0)
            c.tin = $urandom;
        else
            c.tin = 32'(longint'($urandom_range(8 * 65536)) * p / 65536 - 4 * p);
        c.idx = 8'($urandom);
        c.val = 16'($urandom);
        return c;
    endfunction

    function automatic command_t write_cmd(int idx, int val);
        command_t c;
        c = make_cmd(OP_WRITE);
        c.idx = 8'(idx);
        c.val = 16'(val);
        return c;
    endfunction

    task automatic queue_cmd(command_t c);
        pending_cmds = {pending_cmds, c};
    endtask

    // ascending table spread over one period, with random jitter
    task automatic queue_table_fill();
        longint p, v, prev;
        prev = 0;
        p = period_val();
        for (int i = 0; i < AXIS_SIZE; i++)
        begin
            v = (longint'(i) * p) / AXIS_SIZE
              + longint'($urandom_range(32'(p / 512 + 1))) - 1;
            if (v < prev)
                v = prev;
            if (v > 65535)
                v = 65535;
            prev = v;
            queue_cmd(write_cmd(i, int'(v)));
        end
    endtask

    task automatic report_mismatch(string fld, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", fld, got, want, $realtime);
        errors++;
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        range_reg = data[15:0];
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || start || expected_lookups.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // command driver
    always @(posedge clk)
    begin
        lookup_t pred;
        if (start && !busy)
        begin
            pred = predict_lookup(cur);
            expected_lookups = {expected_lookups, pred};
        end
        if (!start || !busy)
        begin
            if (drain && expected_lookups.size() == 0)
                drain = 1'b0;
            if (gap > 0 || drain || pending_cmds.size() == 0 || !rst_n)
            begin
                if (gap > 0)
                    gap--;
                start <= 1'b0;
            end
            else
            begin
                cur = pending_cmds.pop_front();
                operation     <= cur.op;
                window        <= cur.win;
                sample_in     <= cur.smp;
                sample_number <= cur.snum;
                time_in       <= cur.tin;
                entry_index   <= cur.idx;
                entry_value   <= cur.val;
                start         <= 1'b1;
                if (!no_idle)
                begin
                    case ($urandom_range(19))
                        0, 1, 2, 3, 4, 5, 6, 7: gap = 0;
                        19:     gap = $urandom_range(60, 20);
                        default: gap = $urandom_range(4, 1);
                    endcase
                end
                if ($urandom_range(60) == 0)
                    drain = 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        lookup_t want;
        if (done || (start && !busy))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT)
            begin
                $display("FAIL sample_time_calibration_lookup");
                $finish;
            end
        end
        if (done)
        begin
            if (expected_lookups.size() == 0)
            begin
                report_mismatch("unexpected result transaction", 1, 0);
            end
            else
            begin
                want = expected_lookups.pop_front();
                if (time_out !== want.t_out)
                    report_mismatch("time_out", time_out, want.t_out);
                if (sample_out !== want.s_out)
                    report_mismatch("sample_out", sample_out, want.s_out);
                if (bin_width !== want.width)
                    report_mismatch("bin_width", bin_width, want.width);
                if (zero_bin_error !== want.zbin)
                    report_mismatch("zero_bin_error", zero_bin_error, want.zbin);
            end
        end
    end

    initial
    begin
        logic [15:0] ranges[6];
        command_t c;
        ranges = '{TIME_RANGE_RST, 16'd65535, 16'd1, 16'd0, 16'd1000, 16'd0};
        ranges[5] = 16'($urandom_range(65535, 2));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            // upper data bits are don't-care for the register
            apb_write(3'd0, {16'($urandom), ranges[ph]});
            no_idle = (ph == 2);
            if (ph == 0 || ph == 4)
                queue_table_fill();
            if (ph == 0)
            begin
                // extremes of the conversion fields
                c = make_cmd(OP_S2T); c.win = 0;   c.smp = -17'sd65536; queue_cmd(c);
                c = make_cmd(OP_S2T); c.win = 511; c.smp = 17'sd65535;  queue_cmd(c);
                c = make_cmd(OP_S2T); c.win = 0;   c.smp = -17'sd1;     queue_cmd(c);
                c = make_cmd(OP_S2T); c.win = 3;   c.smp = 17'sd255;    queue_cmd(c);
                c = make_cmd(OP_T2S); c.win = 0;   c.tin = 32'sh80000000; queue_cmd(c);
                c = make_cmd(OP_T2S); c.win = 511; c.tin = 32'sh7fffffff; queue_cmd(c);
                c = make_cmd(OP_T2S); c.win = 0;   c.tin = -32'sd1;     queue_cmd(c);
                c = make_cmd(OP_T2S); c.win = 7;   c.tin = 32'sd12345;  queue_cmd(c);
                c = make_cmd(OP_BINW); c.win = 0;   c.snum = -9'sd256;  queue_cmd(c);
                c = make_cmd(OP_BINW); c.win = 511; c.snum = 9'sd255;   queue_cmd(c);
                c = make_cmd(OP_BINW); c.win = 3;   c.snum = 9'sd63;    queue_cmd(c);
                // zero-width first bin hit at time 0
                queue_cmd(write_cmd(0, 0));
                queue_cmd(write_cmd(1, 0));
                c = make_cmd(OP_T2S); c.win = 0; c.tin = 0; queue_cmd(c);
                // unsorted bin: negative width and negative interpolation
                queue_cmd(write_cmd(40, 65535));
                c = make_cmd(OP_BINW); c.win = 0; c.snum = 9'sd40; queue_cmd(c);
                c = make_cmd(OP_BINW); c.win = 0; c.snum = 9'sd39; queue_cmd(c);
                c = make_cmd(OP_S2T); c.win = 0; c.smp = 17'sd10340; queue_cmd(c);
                c = make_cmd(OP_T2S); c.win = 0; c.tin = 32'sd60000; queue_cmd(c);
                // last entry equal to the period: closing bin of zero width
                queue_cmd(write_cmd(255, ranges[0]));
                c = make_cmd(OP_T2S); c.win = 0; c.tin = 32'(ranges[0]) - 1; queue_cmd(c);
                c = make_cmd(OP_BINW); c.win = 3; c.snum = 9'sd63; queue_cmd(c);
            end
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                case ($urandom_range(19))
                    0, 1, 2:          c = make_cmd(OP_WRITE);
                    3, 4, 5, 6, 7, 8: c = make_cmd(OP_S2T);
                    9, 10, 11, 12, 13, 14: c = make_cmd(OP_T2S);
                    default:          c = make_cmd(OP_BINW);
                endcase
                queue_cmd(c);
            end
        end
        wait_idle();
        if (errors == 0 && expected_lookups.size() == 0)
            $display("PASS sample_time_calibration_lookup");
        else
            $display("FAIL sample_time_calibration_lookup");
        $finish;
    end

endmodule
